/* design/slid_pkg.sv */
// Shared constants and types for the ordered list block.
package slid_pkg;

    // Default number of list entries.
    localparam int CAPACITY_DEF = 32;

    // Fixed field widths.
    localparam int DATA_W = 32;
    localparam int POS_W  = 6;
    localparam int KIND_W = 2;

    // Operation codes on the kind input.
    localparam logic [KIND_W-1:0] KIND_FRONT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BACK   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

    // Classified work handed from the front end to the back end.
    typedef enum logic [2:0] {
        OP_FRONT,
        OP_BACK,
        OP_DELETE,
        OP_KEEP,
        OP_DROP
    } op_t;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOVE,
        ST_PUT,
        ST_EMIT
    } back_state_t;

endpackage

/* design/slid_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module slid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data appears the cycle after the address.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/slid_queue.sv */
// Two-entry queue that decouples the command front end from the back end.
module slid_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] data_in,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] data_out
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       fill_reg;
    logic [1:0]       fill_next;

    assign full     = (fill_reg == 2'd2);
    assign empty    = (fill_reg == 2'd0);
    assign data_out = slot_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= data_in;
        end
    end

endmodule

/* design/slid_front.sv */
// Command front end: accepts beats, tracks the list length and classifies each operation.
module slid_front #(
    parameter int CAPACITY = slid_pkg::CAPACITY_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [slid_pkg::KIND_W-1:0]       kind,
    input  logic signed [slid_pkg::DATA_W-1:0] item_value,
    input  logic [slid_pkg::POS_W-1:0]        position,
    input  logic                              q_full,
    output logic                              push,
    output logic [$bits(slid_pkg::op_t)+slid_pkg::DATA_W+$clog2(CAPACITY)
                  +$clog2(CAPACITY+1)-1:0]   entry
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W > slid_pkg::POS_W) ? CNT_W : slid_pkg::POS_W;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    slid_pkg::op_t    op;
    logic             list_full;
    logic             pos_valid;

    assign push      = start && !q_full;
    assign list_full = (count_reg == CNT_W'(CAPACITY));
    assign pos_valid = (CMP_W'(position) < CMP_W'(count_reg));

    // Classify the operation against the length the list will have when it runs.
    always_comb
    begin
        op         = slid_pkg::OP_KEEP;
        count_next = count_reg;
        unique case (kind) inside
            slid_pkg::KIND_FRONT,
            slid_pkg::KIND_BACK:
            begin
                if (list_full)
                begin
                    op = slid_pkg::OP_DROP;
                end
                else
                begin
                    op = (kind == slid_pkg::KIND_FRONT) ? slid_pkg::OP_FRONT
                                                        : slid_pkg::OP_BACK;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            slid_pkg::KIND_DELETE:
            begin
                if (pos_valid)
                begin
                    op         = slid_pkg::OP_DELETE;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                op = slid_pkg::OP_KEEP;
            end
        endcase
    end

    // The queued entry carries the length before the operation.
    assign entry = {op, item_value, IDX_W'(position), count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (push)
        begin
            count_reg <= count_next;
        end
    end

endmodule

/* design/slid_back.sv */
// Back end: shifts the stored list in RAM for each operation and streams it out.
module slid_back #(
    parameter int CAPACITY = slid_pkg::CAPACITY_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_empty,
    input  logic [$bits(slid_pkg::op_t)+slid_pkg::DATA_W+$clog2(CAPACITY)
                  +$clog2(CAPACITY+1)-1:0]    q_entry,
    output logic                               q_pop,
    output logic signed [slid_pkg::DATA_W-1:0] element,
    output logic                               last_flag,
    output logic                               empty_flag,
    output logic                               overflow_flag,
    output logic                               result_valid
);

    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int OP_W    = $bits(slid_pkg::op_t);
    localparam int ENTRY_W = OP_W + slid_pkg::DATA_W + IDX_W + CNT_W;

    // Queue entry fields.
    slid_pkg::op_t               q_op;
    logic [slid_pkg::DATA_W-1:0] q_value;
    logic [IDX_W-1:0]            q_pos;
    logic [CNT_W-1:0]            q_cnt;

    assign q_op    = slid_pkg::op_t'(q_entry[ENTRY_W-1 -: OP_W]);
    assign q_value = q_entry[IDX_W+CNT_W +: slid_pkg::DATA_W];
    assign q_pos   = q_entry[CNT_W +: IDX_W];
    assign q_cnt   = q_entry[CNT_W-1:0];

    // RAM port signals.
    logic                        ram_we;
    logic [IDX_W-1:0]            ram_waddr;
    logic [slid_pkg::DATA_W-1:0] ram_wdata;
    logic                        ram_re;
    logic [IDX_W-1:0]            ram_raddr;
    logic [slid_pkg::DATA_W-1:0] ram_rdata;

    slid_pkg::back_state_t       state_reg, state_next;
    logic [slid_pkg::DATA_W-1:0] value_reg, value_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        ovf_reg, ovf_next;
    logic                        put_reg, put_next;
    logic [IDX_W-1:0]            mv_rd_reg, mv_rd_next;
    logic [IDX_W-1:0]            mv_wr_reg, mv_wr_next;
    logic [CNT_W-1:0]            mv_left_reg, mv_left_next;
    logic                        mv_pend_reg, mv_pend_next;
    logic                        mv_up_reg, mv_up_next;
    logic [IDX_W-1:0]            em_idx_reg, em_idx_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        out_last_reg, out_last_next;
    logic                        out_empty_reg, out_empty_next;
    logic                        out_ovf_reg, out_ovf_next;
    logic                        em_last;

    slid_ram #(
        .WIDTH (slid_pkg::DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign em_last = ((CNT_W'(em_idx_reg) + CNT_W'(1)) == cnt_reg);

    // Sequencer: setup, element moves, front write, then one result beat per cycle.
    always_comb
    begin
        state_next     = state_reg;
        value_next     = value_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        put_next       = put_reg;
        mv_rd_next     = mv_rd_reg;
        mv_wr_next     = mv_wr_reg;
        mv_left_next   = mv_left_reg;
        mv_pend_next   = mv_pend_reg;
        mv_up_next     = mv_up_reg;
        em_idx_next    = em_idx_reg;
        out_valid_next = 1'b0;
        out_last_next  = 1'b0;
        out_empty_next = 1'b0;
        out_ovf_next   = ovf_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = mv_wr_reg;
        ram_wdata      = ram_rdata;
        ram_re         = 1'b0;
        ram_raddr      = mv_rd_reg;

        unique case (state_reg)
            slid_pkg::ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop        = 1'b1;
                    value_next   = q_value;
                    ovf_next     = (q_op == slid_pkg::OP_DROP);
                    put_next     = 1'b0;
                    mv_pend_next = 1'b0;
                    em_idx_next  = '0;
                    unique case (q_op)
                        slid_pkg::OP_FRONT:
                        begin
                            // Shift everything up one place, last element first.
                            mv_rd_next   = IDX_W'(q_cnt - CNT_W'(1));
                            mv_left_next = q_cnt;
                            mv_up_next   = 1'b1;
                            put_next     = 1'b1;
                            cnt_next     = q_cnt + CNT_W'(1);
                            state_next   = slid_pkg::ST_MOVE;
                        end
                        slid_pkg::OP_BACK:
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = IDX_W'(q_cnt);
                            ram_wdata  = q_value;
                            cnt_next   = q_cnt + CNT_W'(1);
                            state_next = slid_pkg::ST_EMIT;
                        end
                        slid_pkg::OP_DELETE:
                        begin
                            // Close the gap: elements after the position move down.
                            mv_rd_next   = q_pos + IDX_W'(1);
                            mv_left_next = q_cnt - CNT_W'(q_pos) - CNT_W'(1);
                            mv_up_next   = 1'b0;
                            cnt_next     = q_cnt - CNT_W'(1);
                            state_next   = slid_pkg::ST_MOVE;
                        end
                        default:
                        begin
                            cnt_next   = q_cnt;
                            state_next = slid_pkg::ST_EMIT;
                        end
                    endcase
                end
            end

            slid_pkg::ST_MOVE:
            begin
                // Read one element per cycle and write it back in the next cycle.
                if (mv_left_reg != '0)
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = mv_rd_reg;
                    mv_left_next = mv_left_reg - CNT_W'(1);
                    mv_rd_next   = mv_up_reg ? (mv_rd_reg - IDX_W'(1))
                                             : (mv_rd_reg + IDX_W'(1));
                    mv_wr_next   = mv_up_reg ? (mv_rd_reg + IDX_W'(1))
                                             : (mv_rd_reg - IDX_W'(1));
                    mv_pend_next = 1'b1;
                end
                else
                begin
                    mv_pend_next = 1'b0;
                end
                if (mv_pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = mv_wr_reg;
                    ram_wdata = ram_rdata;
                end
                if ((mv_left_reg == '0) && !mv_pend_reg)
                begin
                    state_next = put_reg ? slid_pkg::ST_PUT : slid_pkg::ST_EMIT;
                end
            end

            slid_pkg::ST_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = value_reg;
                state_next = slid_pkg::ST_EMIT;
            end

            slid_pkg::ST_EMIT:
            begin
                out_valid_next = 1'b1;
                if (cnt_reg == '0)
                begin
                    out_empty_next = 1'b1;
                    out_last_next  = 1'b1;
                    state_next     = slid_pkg::ST_IDLE;
                end
                else
                begin
                    ram_re        = 1'b1;
                    ram_raddr     = em_idx_reg;
                    out_last_next = em_last;
                    em_idx_next   = em_idx_reg + IDX_W'(1);
                    if (em_last)
                    begin
                        state_next = slid_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = slid_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= slid_pkg::ST_IDLE;
            mv_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mv_pend_reg   <= mv_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge clk)
    begin
        value_reg     <= value_next;
        cnt_reg       <= cnt_next;
        ovf_reg       <= ovf_next;
        put_reg       <= put_next;
        mv_rd_reg     <= mv_rd_next;
        mv_wr_reg     <= mv_wr_next;
        mv_left_reg   <= mv_left_next;
        mv_up_reg     <= mv_up_next;
        em_idx_reg    <= em_idx_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
        out_ovf_reg   <= out_ovf_next;
    end

    // Result beat: element comes straight from the RAM read register.
    assign result_valid  = out_valid_reg;
    assign last_flag     = out_last_reg;
    assign empty_flag    = out_empty_reg;
    assign overflow_flag = out_ovf_reg;
    assign element       = out_empty_reg ? '0 : ram_rdata;

endmodule

/* design/sequence_list_insert_delete.sv */
// Top level of the ordered list block with front insert, back append and delete at position.
//
// Each accepted command (start high while busy is low) updates a list of up to CAPACITY
// signed 32-bit values and then streams the whole list, front to back, as one result beat
// per cycle on consecutive cycles, flagged by result_valid; last_flag marks the final beat,
// and an empty list gives a single beat with empty_flag set and element zero. An insert into
// a full list is dropped and overflow_flag is set on every beat of that operation. The list
// lives in a RAM with one read and one write port. For each command the back end first
// takes it from the queue; a front insert then moves the elements up one place, last
// element first, and writes the new front, a delete moves the elements after the position
// down one place, and an append, a dropped insert or a no-op moves nothing. It then issues
// one beat per element of the new length (one if empty) on consecutive cycles, and each
// beat is registered and shows on the outputs in the cycle after it is issued. The back
// end takes the next command only after the last beat of the current one. Up to two
// commands wait in a queue; busy is high while the queue is full. Results cannot be held
// off by the receiver.
module sequence_list_insert_delete #(
    parameter int CAPACITY = slid_pkg::CAPACITY_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [slid_pkg::KIND_W-1:0]        kind,
    input  logic signed [slid_pkg::DATA_W-1:0] item_value,
    input  logic [slid_pkg::POS_W-1:0]         position,
    output logic                               result_valid,
    output logic signed [slid_pkg::DATA_W-1:0] element,
    output logic                               last_flag,
    output logic                               empty_flag,
    output logic                               overflow_flag
);

    localparam int ENTRY_W = $bits(slid_pkg::op_t) + slid_pkg::DATA_W
                             + $clog2(CAPACITY) + $clog2(CAPACITY + 1);

    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_empty;
    logic [ENTRY_W-1:0] q_in;
    logic [ENTRY_W-1:0] q_out;

    assign busy = q_full;

    // Front end: accept and classify commands.
    slid_front #(
        .CAPACITY (CAPACITY)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .kind       (kind),
        .item_value (item_value),
        .position   (position),
        .q_full     (q_full),
        .push       (q_push),
        .entry      (q_in)
    );

    // Command queue between the two halves.
    slid_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .data_in  (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .data_out (q_out)
    );

    // Back end: list storage, shifting and output streaming.
    slid_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_entry       (q_out),
        .q_pop         (q_pop),
        .element       (element),
        .last_flag     (last_flag),
        .empty_flag    (empty_flag),
        .overflow_flag (overflow_flag),
        .result_valid  (result_valid)
    );

`ifndef ASSERT_OFF
    // An empty-list beat is the only beat of its operation and carries a zero element.
    a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && empty_flag) |-> (last_flag && (element == '0)))
        else $error("empty list beat without last flag or with nonzero element");

    // A dropped insert only happens on a full list, so its output is never empty.
    a_overflow_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && overflow_flag) |-> !empty_flag)
        else $error("overflow reported on an empty list");

    // The list streams out without gaps until its last beat.
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last_flag) |=> result_valid)
        else $error("gap in the list output stream");
`endif

endmodule
